@@ design/cpcr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpcr_pkg: shared types, constants and step functions
// Field layouts of a pair request and its result, widths of the internal
// datapath, and the single steps of the square root and divider pipelines.
// ----------------------------------------------------------------------------
package cpcr_pkg;

  localparam int FRAC_BITS  = 8;
  // distance carries 8 extra fraction bits on top of FRAC_BITS
  localparam int NEAR_LIMIT = (1 << (FRAC_BITS + 8)) / 10000;

  localparam int POS_W  = 24;
  localparam int RAD_W  = 17;
  localparam int MASS_W = 16;
  localparam int REST_W = 16;
  localparam int KIND_W = 2;

  localparam logic [REST_W-1:0] REST_RESET = 16'd58982;

  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEPARATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IMPULSE  = 2'd2;

  localparam int DIFF_W   = POS_W + 1;
  localparam int SQR_W    = 2 * DIFF_W;
  localparam int RSUM_W   = RAD_W + 1;
  localparam int RSQ_W    = 2 * RSUM_W;
  localparam int ADJ_W    = RSUM_W;          // |dx| while in contact
  localparam int DIST_SH  = 16;              // d2 scaled before the root
  localparam int SQ_IN_W  = RSQ_W + DIST_SH;
  localparam int SQ_W     = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_W + 2;
  localparam int PEN_SH   = DIST_SH / 2;     // radius sum to distance scale
  localparam int NRM_SH   = 16 + PEN_SH;     // Q.16 normal over scaled distance
  localparam int W_FRAC   = 16;

  localparam int DN_W      = 45;
  localparam int DD_W      = SQ_W + 1;
  localparam int DQ_W      = 18;
  localparam int DIV_LANES = 6;
  localparam int LANE_SX   = 0;
  localparam int LANE_SY   = 1;
  localparam int LANE_NX   = 2;
  localparam int LANE_NY   = 3;
  localparam int LANE_WA   = 4;
  localparam int LANE_WB   = 5;

  localparam int NRM_W  = 17;
  localparam int PRD_W  = DIFF_W + NRM_W + 1;
  localparam int SP_W   = PRD_W + 1;
  localparam int KP_W   = SP_W + REST_W;
  localparam int K_W    = 44;
  localparam int IP_W   = K_W + NRM_W + 1;
  localparam int IMP_W  = K_W;
  localparam int DP_W   = IMP_W + NRM_W + 1;
  localparam int DEL_W  = 30;
  localparam int SAT_W  = 31;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (POS_W - 1) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-(2 ** (POS_W - 1)));

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_a_x;
    logic signed [POS_W-1:0]  pos_a_y;
    logic        [RAD_W-1:0]  radius_a;
    logic        [MASS_W-1:0] mass_a;
    logic signed [POS_W-1:0]  vel_a_x;
    logic signed [POS_W-1:0]  vel_a_y;
    logic signed [POS_W-1:0]  pos_b_x;
    logic signed [POS_W-1:0]  pos_b_y;
    logic        [RAD_W-1:0]  radius_b;
    logic        [MASS_W-1:0] mass_b;
    logic signed [POS_W-1:0]  vel_b_x;
    logic signed [POS_W-1:0]  vel_b_y;
  } pair_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  new_pos_a_x;
    logic signed [POS_W-1:0]  new_pos_a_y;
    logic signed [POS_W-1:0]  new_vel_a_x;
    logic signed [POS_W-1:0]  new_vel_a_y;
    logic signed [POS_W-1:0]  new_pos_b_x;
    logic signed [POS_W-1:0]  new_pos_b_y;
    logic signed [POS_W-1:0]  new_vel_b_x;
    logic signed [POS_W-1:0]  new_vel_b_y;
    logic        [KIND_W-1:0] contact_kind;
  } result_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_W-1:0]     root;
  } sq_t;

  typedef struct packed {
    logic [DN_W-1:0] rem;
    logic [DD_W-1:0] den;
    logic [DQ_W-1:0] quo;
  } div_t;

  typedef struct packed {
    pair_t             p;
    logic [ADJ_W-1:0]  adx;
    logic [ADJ_W-1:0]  ady;
    logic              negx;
    logic              negy;
    logic [RSUM_W-1:0] rsum;
    logic              contact;
  } sq_side_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  ax;
    logic signed [POS_W-1:0]  ay;
    logic signed [POS_W-1:0]  bx;
    logic signed [POS_W-1:0]  by;
    logic signed [POS_W-1:0]  vax;
    logic signed [POS_W-1:0]  vay;
    logic signed [POS_W-1:0]  vbx;
    logic signed [POS_W-1:0]  vby;
    logic signed [DIFF_W-1:0] dvx;
    logic signed [DIFF_W-1:0] dvy;
    logic                     negx;
    logic                     negy;
    logic                     live;
    logic                     mzero;
  } dv_side_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pax;
    logic signed [POS_W-1:0] pay;
    logic signed [POS_W-1:0] pbx;
    logic signed [POS_W-1:0] pby;
    logic signed [POS_W-1:0] vax;
    logic signed [POS_W-1:0] vay;
    logic signed [POS_W-1:0] vbx;
    logic signed [POS_W-1:0] vby;
    logic [NRM_W-1:0]        mnx;
    logic [NRM_W-1:0]        mny;
    logic                    negx;
    logic                    negy;
    logic                    live;
    logic                    recede;
  } tail_t;

  // one result bit of the integer square root
  function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair_bits);
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] sub;
    sq_t r;
    trial = {s.rem, pair_bits};
    sub   = {{(SQ_REM_W - SQ_W){1'b0}}, s.root, 2'b01};
    if (trial >= sub) begin
      r.rem  = SQ_REM_W'(trial - sub);
      r.root = {s.root[SQ_W-2:0], 1'b1};
    end else begin
      r.rem  = SQ_REM_W'(trial);
      r.root = {s.root[SQ_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of restoring division
  function automatic div_t div_step(input div_t s, input int unsigned bit_pos);
    logic [DN_W-1:0] shifted;
    div_t r;
    r       = s;
    shifted = {{(DN_W - DD_W){1'b0}}, s.den} << bit_pos;
    if (s.rem >= shifted) begin
      r.rem          = s.rem - shifted;
      r.quo[bit_pos] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[POS_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/cpcr_chan_if.sv @@
// ----------------------------------------------------------------------------
// cpcr_chan_if: valid/ready channel
// Carries one request of type T per handshake.
// ----------------------------------------------------------------------------
interface cpcr_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/circle_pair_collision_response_top.sv @@
// ----------------------------------------------------------------------------
// circle_pair_collision_response_top: 2-D circle pair collision response
// Pushes an overlapping pair apart and applies a restitution impulse.
// ----------------------------------------------------------------------------
// Channels: pair takes one candidate pair per request (centres, radii, masses,
// velocities of A and B); result returns the corrected centres, velocities and
// contact_kind; cfg writes the restitution register and is always ready.
// Path of a request: stages A to C for differences, squares and contact test,
// the square root (one root bit per stage), stage D for the dividends, six
// parallel dividers (one quotient bit per stage), stages E to I for the
// normal, impulse and velocity products, and 1 output register.
// Throughput is one request per cycle unless the receiver stalls; every stage
// holds at most one request. When the receiver stalls with a result waiting,
// the whole pipeline holds and pair.ready drops in the same cycle; nothing is
// dropped or repeated. Reset (rst, synchronous) empties the pipeline and loads
// restitution 58982. Write cfg only while no request is in flight.
// ----------------------------------------------------------------------------
module circle_pair_collision_response_top (
  input logic        clk,
  input logic        rst,
  cpcr_chan_if.sink   pair,
  cpcr_chan_if.source result,
  cpcr_chan_if.sink   cfg
);
  import cpcr_pkg::*;

  logic              adv;
  logic [REST_W-1:0] restitution;

  // ---- stage A: differences
  logic                     a_v;
  pair_t                    a_p;
  logic signed [DIFF_W-1:0] a_dx, a_dy;
  logic [RSUM_W-1:0]        a_rsum;
  // ---- stage B: squares
  logic                     b_v;
  pair_t                    b_p;
  logic signed [SQR_W-1:0]  b_dx2, b_dy2;
  logic [RSQ_W-1:0]         b_rsum2;
  logic [RSUM_W-1:0]        b_rsum;
  logic [ADJ_W-1:0]         b_adx, b_ady;
  logic                     b_negx, b_negy;
  // ---- stage C: contact test
  logic                     c_v;
  logic [RSQ_W-1:0]         c_x;
  sq_side_t                 c_side;
  logic [SQR_W-1:0]         d2;
  // ---- square root pipeline
  sq_t                      sq_st   [SQ_W];
  logic [SQ_IN_W-1:0]       sq_x    [SQ_W];
  sq_side_t                 sq_side [SQ_W];
  logic                     sq_v    [SQ_W];
  // ---- stage D: dividends
  logic                     d_v;
  div_t                     d_lane  [DIV_LANES];
  div_t                     d_lane_next [DIV_LANES];
  dv_side_t                 d_side;
  dv_side_t                 d_side_next;
  logic [SQ_W-1:0]          dlen, pen;
  sq_side_t                 sd;
  logic [DN_W-1:0]          prod_x, prod_y;
  logic [MASS_W:0]          msum;
  // ---- divider pipeline
  div_t                     dv_st   [DIV_LANES][DQ_W];
  dv_side_t                 dv_side [DQ_W];
  logic                     dv_v    [DQ_W];
  // ---- stages E to I
  logic                     e_v, f_v, g_v, h_v, i_v;
  tail_t                    e_t, f_t, g_t, h_t, i_t;
  tail_t                    e_t_next;
  tail_t                    f_t_next;
  logic signed [PRD_W-1:0]  e_px, e_py;
  logic signed [SP_W-1:0]   e_sp;
  logic [NRM_W-1:0]         e_wa, e_wb, f_wa, f_wb, g_wa, g_wb;
  logic signed [SP_W-1:0]   f_sp;
  logic [K_W-1:0]           g_k;
  logic [IMP_W-1:0]         h_ia, h_ib;
  logic [DEL_W-1:0]         i_dax, i_day, i_dbx, i_dby;
  logic signed [DQ_W:0]     e_sx, e_sy;
  logic signed [NRM_W:0]    e_nx, e_ny;
  dv_side_t                 es;
  logic [KP_W-1:0]          kprod;
  logic [IP_W-1:0]          iprod_a, iprod_b;
  logic [DP_W-1:0]          dp_ax, dp_ay, dp_bx, dp_by;
  // ---- output register
  logic                     res_v;
  result_t                  res, res_next;

  assign adv          = !res_v || result.ready;
  assign pair.ready   = adv;
  assign cfg.ready    = 1'b1;
  assign result.valid = res_v;
  assign result.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= REST_RESET;
    end else if (cfg.valid) begin
      restitution <= cfg.data;
    end
  end

  // ---------------------------------------------------------------- A, B, C
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (adv) begin
      a_v <= pair.valid;
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  assign d2 = SQR_W'($unsigned(b_dx2)) + SQR_W'($unsigned(b_dy2));

  always_ff @(posedge clk) begin
    if (adv) begin
      a_p    <= pair.data;
      a_dx   <= DIFF_W'(pair.data.pos_a_x) - DIFF_W'(pair.data.pos_b_x);
      a_dy   <= DIFF_W'(pair.data.pos_a_y) - DIFF_W'(pair.data.pos_b_y);
      a_rsum <= RSUM_W'(pair.data.radius_a) + RSUM_W'(pair.data.radius_b);

      b_p     <= a_p;
      b_dx2   <= a_dx * a_dx;
      b_dy2   <= a_dy * a_dy;
      b_rsum2 <= a_rsum * a_rsum;
      b_rsum  <= a_rsum;
      b_adx   <= ADJ_W'(a_dx[DIFF_W-1] ? -a_dx : a_dx);
      b_ady   <= ADJ_W'(a_dy[DIFF_W-1] ? -a_dy : a_dy);
      b_negx  <= a_dx[DIFF_W-1];
      b_negy  <= a_dy[DIFF_W-1];

      // beyond the radius-sum bound d2 is not looked at again
      c_x            <= d2[RSQ_W-1:0];
      c_side.p       <= b_p;
      c_side.adx     <= b_adx;
      c_side.ady     <= b_ady;
      c_side.negx    <= b_negx;
      c_side.negy    <= b_negy;
      c_side.rsum    <= b_rsum;
      c_side.contact <= (d2 != '0) && (d2 < SQR_W'(b_rsum2));
    end
  end

  // ---------------------------------------------------------------- root
  for (genvar j = 0; j < SQ_W; j++) begin : g_sqrt
    sq_t                st_in;
    logic [SQ_IN_W-1:0] x_in;
    sq_side_t           sd_in;
    logic               v_in;

    if (j == 0) begin : g_first
      assign st_in = '0;
      assign x_in  = {c_x, {DIST_SH{1'b0}}};
      assign sd_in = c_side;
      assign v_in  = c_v;
    end else begin : g_next
      assign st_in = sq_st[j-1];
      assign x_in  = sq_x[j-1];
      assign sd_in = sq_side[j-1];
      assign v_in  = sq_v[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j] <= 1'b0;
      end else if (adv) begin
        sq_v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_st[j]   <= sqrt_step(st_in, x_in[SQ_IN_W-1 -: 2]);
        sq_x[j]    <= x_in << 2;
        sq_side[j] <= sd_in;
      end
    end
  end

  // ---------------------------------------------------------------- D
  assign dlen = sq_st[SQ_W-1].root;
  assign sd   = sq_side[SQ_W-1];

  always_comb begin
    pen    = {sd.rsum, {PEN_SH{1'b0}}} - dlen;
    prod_x = pen * sd.adx;
    prod_y = pen * sd.ady;
    msum   = {1'b0, sd.p.mass_a} + {1'b0, sd.p.mass_b};

    d_lane_next[LANE_SX].rem = prod_x + DN_W'(dlen);
    d_lane_next[LANE_SX].den = {dlen, 1'b0};
    d_lane_next[LANE_SY].rem = prod_y + DN_W'(dlen);
    d_lane_next[LANE_SY].den = {dlen, 1'b0};
    d_lane_next[LANE_NX].rem = DN_W'({sd.adx, {NRM_SH{1'b0}}}) + DN_W'(dlen >> 1);
    d_lane_next[LANE_NX].den = DD_W'(dlen);
    d_lane_next[LANE_NY].rem = DN_W'({sd.ady, {NRM_SH{1'b0}}}) + DN_W'(dlen >> 1);
    d_lane_next[LANE_NY].den = DD_W'(dlen);
    d_lane_next[LANE_WA].rem = DN_W'({sd.p.mass_a, {W_FRAC{1'b0}}}) + DN_W'(msum >> 1);
    d_lane_next[LANE_WA].den = DD_W'(msum);
    d_lane_next[LANE_WB].rem = DN_W'({sd.p.mass_b, {W_FRAC{1'b0}}}) + DN_W'(msum >> 1);
    d_lane_next[LANE_WB].den = DD_W'(msum);
    for (int l = 0; l < DIV_LANES; l++) begin
      d_lane_next[l].quo = '0;
    end

    d_side_next.ax    = sd.p.pos_a_x;
    d_side_next.ay    = sd.p.pos_a_y;
    d_side_next.bx    = sd.p.pos_b_x;
    d_side_next.by    = sd.p.pos_b_y;
    d_side_next.vax   = sd.p.vel_a_x;
    d_side_next.vay   = sd.p.vel_a_y;
    d_side_next.vbx   = sd.p.vel_b_x;
    d_side_next.vby   = sd.p.vel_b_y;
    d_side_next.dvx   = DIFF_W'(sd.p.vel_a_x) - DIFF_W'(sd.p.vel_b_x);
    d_side_next.dvy   = DIFF_W'(sd.p.vel_a_y) - DIFF_W'(sd.p.vel_b_y);
    d_side_next.negx  = sd.negx;
    d_side_next.negy  = sd.negy;
    // distances at or below 0.0001 leave the pair untouched
    d_side_next.live  = sd.contact && (dlen > SQ_W'(NEAR_LIMIT));
    d_side_next.mzero = (msum == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= sq_v[SQ_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_lane <= d_lane_next;
      d_side <= d_side_next;
    end
  end

  // ---------------------------------------------------------------- dividers
  for (genvar k = 0; k < DQ_W; k++) begin : g_div
    dv_side_t side_in;
    logic     v_in;

    if (k == 0) begin : g_first
      assign side_in = d_side;
      assign v_in    = d_v;
    end else begin : g_next
      assign side_in = dv_side[k-1];
      assign v_in    = dv_v[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (adv) begin
        dv_v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side[k] <= side_in;
      end
    end

    for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
      div_t st_in;

      if (k == 0) begin : g_first
        assign st_in = d_lane[l];
      end else begin : g_next
        assign st_in = dv_st[l][k-1];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_st[l][k] <= div_step(st_in, DQ_W - 1 - k);
        end
      end
    end
  end

  // ---------------------------------------------------------------- E
  assign es = dv_side[DQ_W-1];

  always_comb begin
    e_sx = signed'({1'b0, dv_st[LANE_SX][DQ_W-1].quo});
    e_sy = signed'({1'b0, dv_st[LANE_SY][DQ_W-1].quo});
    if (es.negx) begin
      e_sx = -e_sx;
    end
    if (es.negy) begin
      e_sy = -e_sy;
    end
    // normal points from A to B
    e_nx = signed'({1'b0, dv_st[LANE_NX][DQ_W-1].quo[NRM_W-1:0]});
    e_ny = signed'({1'b0, dv_st[LANE_NY][DQ_W-1].quo[NRM_W-1:0]});
    if (!es.negx) begin
      e_nx = -e_nx;
    end
    if (!es.negy) begin
      e_ny = -e_ny;
    end

    e_t_next.vax    = es.vax;
    e_t_next.vay    = es.vay;
    e_t_next.vbx    = es.vbx;
    e_t_next.vby    = es.vby;
    e_t_next.mnx    = dv_st[LANE_NX][DQ_W-1].quo[NRM_W-1:0];
    e_t_next.mny    = dv_st[LANE_NY][DQ_W-1].quo[NRM_W-1:0];
    e_t_next.negx   = es.negx;
    e_t_next.negy   = es.negy;
    e_t_next.live   = es.live;
    e_t_next.recede = 1'b0;
    if (es.live) begin
      e_t_next.pax = sat_pos(SAT_W'(es.ax) + SAT_W'(e_sx));
      e_t_next.pay = sat_pos(SAT_W'(es.ay) + SAT_W'(e_sy));
      e_t_next.pbx = sat_pos(SAT_W'(es.bx) - SAT_W'(e_sx));
      e_t_next.pby = sat_pos(SAT_W'(es.by) - SAT_W'(e_sy));
    end else begin
      e_t_next.pax = es.ax;
      e_t_next.pay = es.ay;
      e_t_next.pbx = es.bx;
      e_t_next.pby = es.by;
    end
  end

  // ---------------------------------------------------------------- E..I
  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
    end else if (adv) begin
      e_v <= dv_v[DQ_W-1];
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      i_v <= h_v;
    end
  end

  assign e_sp    = SP_W'(e_px) + SP_W'(e_py);
  assign kprod   = KP_W'(f_sp[SP_W-2:0]) * KP_W'(restitution);
  assign iprod_a = IP_W'(g_k) * IP_W'(g_wb);
  assign iprod_b = IP_W'(g_k) * IP_W'(g_wa);
  assign dp_ax   = DP_W'(h_ia) * DP_W'(h_t.mnx);
  assign dp_ay   = DP_W'(h_ia) * DP_W'(h_t.mny);
  assign dp_bx   = DP_W'(h_ib) * DP_W'(h_t.mnx);
  assign dp_by   = DP_W'(h_ib) * DP_W'(h_t.mny);

  // negative relative speed along the normal: the pair recedes
  always_comb begin
    f_t_next        = e_t;
    f_t_next.recede = e_sp[SP_W-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_t  <= e_t_next;
      e_px <= es.dvx * e_nx;
      e_py <= es.dvy * e_ny;
      // both masses zero: no share of the impulse for either
      e_wa <= es.mzero ? '0 : dv_st[LANE_WA][DQ_W-1].quo[NRM_W-1:0];
      e_wb <= es.mzero ? '0 : dv_st[LANE_WB][DQ_W-1].quo[NRM_W-1:0];

      f_t  <= f_t_next;
      f_sp <= e_sp;
      f_wa <= e_wa;
      f_wb <= e_wb;

      g_t  <= f_t;
      g_k  <= K_W'((kprod + KP_W'(1 << 14)) >> 15);
      g_wa <= f_wa;
      g_wb <= f_wb;

      h_t  <= g_t;
      h_ia <= IMP_W'((iprod_a + IP_W'(1 << 15)) >> 16);
      h_ib <= IMP_W'((iprod_b + IP_W'(1 << 15)) >> 16);

      i_t   <= h_t;
      i_dax <= DEL_W'((dp_ax + (DP_W'(1) << 31)) >> 32);
      i_day <= DEL_W'((dp_ay + (DP_W'(1) << 31)) >> 32);
      i_dbx <= DEL_W'((dp_bx + (DP_W'(1) << 31)) >> 32);
      i_dby <= DEL_W'((dp_by + (DP_W'(1) << 31)) >> 32);
    end
  end

  // ---------------------------------------------------------------- J
  always_comb begin
    res_next.new_pos_a_x = i_t.pax;
    res_next.new_pos_a_y = i_t.pay;
    res_next.new_pos_b_x = i_t.pbx;
    res_next.new_pos_b_y = i_t.pby;
    res_next.new_vel_a_x = i_t.vax;
    res_next.new_vel_a_y = i_t.vay;
    res_next.new_vel_b_x = i_t.vbx;
    res_next.new_vel_b_y = i_t.vby;
    res_next.contact_kind = KIND_NONE;
    if (i_t.live && i_t.recede) begin
      res_next.contact_kind = KIND_SEPARATE;
    end else if (i_t.live) begin
      res_next.contact_kind = KIND_IMPULSE;
      // A moves against the normal, B along it
      if (i_t.negx) begin
        res_next.new_vel_a_x = sat_pos(SAT_W'(i_t.vax) - SAT_W'(i_dax));
        res_next.new_vel_b_x = sat_pos(SAT_W'(i_t.vbx) + SAT_W'(i_dbx));
      end else begin
        res_next.new_vel_a_x = sat_pos(SAT_W'(i_t.vax) + SAT_W'(i_dax));
        res_next.new_vel_b_x = sat_pos(SAT_W'(i_t.vbx) - SAT_W'(i_dbx));
      end
      if (i_t.negy) begin
        res_next.new_vel_a_y = sat_pos(SAT_W'(i_t.vay) - SAT_W'(i_day));
        res_next.new_vel_b_y = sat_pos(SAT_W'(i_t.vby) + SAT_W'(i_dby));
      end else begin
        res_next.new_vel_a_y = sat_pos(SAT_W'(i_t.vay) + SAT_W'(i_day));
        res_next.new_vel_b_y = sat_pos(SAT_W'(i_t.vby) - SAT_W'(i_dby));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (adv) begin
      res_v <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

@@ design/cpcr_check.sv @@
// ----------------------------------------------------------------------------
// cpcr_check: port-level checks for the collision response block
// Flow control, reset and result hold while the receiver stalls.
// ----------------------------------------------------------------------------
module cpcr_check (
  input logic              clk,
  input logic              rst,
  input logic              pair_valid,
  input logic              pair_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic              cfg_ready,
  input cpcr_pkg::result_t result_data
);
  import cpcr_pkg::*;

  // a stalled result stays put with its contents
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  // the pipeline moves exactly when the output slot is free or taken
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    pair_ready == (!result_valid || result_ready))
    else $error("pair.ready does not follow output stall");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    pair_valid || !pair_valid |-> cfg_ready)
    else $error("configuration port not ready");

endmodule

bind circle_pair_collision_response_top cpcr_check u_cpcr_check (
  .clk          (clk),
  .rst          (rst),
  .pair_valid   (pair.valid),
  .pair_ready   (pair.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .cfg_ready    (cfg.ready),
  .result_data  (result.data)
);

@@ tb/tb_circle_pair_collision_response_top.sv @@
// ----------------------------------------------------------------------------
// tb_circle_pair_collision_response_top: collision response pipeline bench
// Drives candidate pairs with random gaps and result stalls, predicts every
// result with an independent integer model and compares each result as a whole.
// ----------------------------------------------------------------------------
module tb_circle_pair_collision_response_top;
  import cpcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 54;
  localparam int IDLE_MAX  = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpcr_chan_if #(.T(pair_t))              pair_ch ();
  cpcr_chan_if #(.T(result_t))            res_ch ();
  cpcr_chan_if #(.T(logic [REST_W-1:0]))  cfg_ch ();

  circle_pair_collision_response_top dut (
    .clk(clk), .rst(rst), .pair(pair_ch.sink), .result(res_ch.source), .cfg(cfg_ch.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [REST_W-1:0] rest_q;
  pair_t   pending_pairs[$];
  result_t expected_results[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      stall_hold = 1'b0;
  int      hold_len = 0;
  bit      pair_taken = 1'b0;
  bit      res_taken = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned umag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[POS_W-1:0];
  endfunction

  function automatic longint unit_normal(longint d, longint unsigned dlen);
    longint unsigned m = ((umag(d) << 24) + dlen / 2) / dlen;
    return d > 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint scaled_impulse(longint unsigned imp, longint n);
    longint m = longint'((imp * umag(n) + (64'd1 << 31)) >> 32);
    return n < 0 ? -m : m;
  endfunction

  function automatic result_t resolve_pair(pair_t p, logic [REST_W-1:0] rest);
    result_t r;
    longint ax = p.pos_a_x, ay = p.pos_a_y, bx = p.pos_b_x, by = p.pos_b_y;
    longint vax = p.vel_a_x, vay = p.vel_a_y, vbx = p.vel_b_x, vby = p.vel_b_y;
    longint dx, dy, sx, sy, nx, ny, sp;
    longint unsigned adx, ady, d2, rsum, dlen, pen, kk, ms, wa, wb, ia, ib;
    logic [KIND_W-1:0] kind = KIND_NONE;
    dx = ax - bx;
    dy = ay - by;
    adx = umag(dx);
    ady = umag(dy);
    d2 = adx * adx + ady * ady;
    rsum = longint'(p.radius_a) + longint'(p.radius_b);
    if (d2 != 0 && d2 < rsum * rsum) begin
      dlen = int_sqrt(d2 << 16);
      if (dlen * 10000 > (64'd1 << (FRAC_BITS + 8))) begin
        pen = rsum * 256 - dlen;
        sx = longint'((pen * adx + dlen) / (2 * dlen));
        sy = longint'((pen * ady + dlen) / (2 * dlen));
        if (dx < 0) sx = -sx;
        if (dy < 0) sy = -sy;
        ax += sx; ay += sy; bx -= sx; by -= sy;
        nx = unit_normal(dx, dlen);
        ny = unit_normal(dy, dlen);
        sp = (vax - vbx) * nx + (vay - vby) * ny;
        kind = KIND_SEPARATE;
        if (sp >= 0) begin
          kk = (longint'(sp) * 2 * longint'(rest) + 32768) >> 16;
          ms = longint'(p.mass_a) + longint'(p.mass_b);
          wa = 0;
          wb = 0;
          if (ms != 0) begin
            wb = ((longint'(p.mass_b) << 16) + ms / 2) / ms;
            wa = ((longint'(p.mass_a) << 16) + ms / 2) / ms;
          end
          ia = (kk * wb + 32768) >> 16;
          ib = (kk * wa + 32768) >> 16;
          vax -= scaled_impulse(ia, nx);
          vay -= scaled_impulse(ia, ny);
          vbx += scaled_impulse(ib, nx);
          vby += scaled_impulse(ib, ny);
          kind = KIND_IMPULSE;
        end
      end
    end
    r.new_pos_a_x = clamp24(ax);
    r.new_pos_a_y = clamp24(ay);
    r.new_vel_a_x = clamp24(vax);
    r.new_vel_a_y = clamp24(vay);
    r.new_pos_b_x = clamp24(bx);
    r.new_pos_b_y = clamp24(by);
    r.new_vel_b_x = clamp24(vbx);
    r.new_vel_b_y = clamp24(vby);
    r.contact_kind = kind;
    return r;
  endfunction

  task automatic queue_pair(pair_t q);
    pending_pairs.insert(pending_pairs.size(), q);
  endtask

  // ---------------------------------------------------------------- driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      pair_ch.valid <= 1'b0;
    end else if (pair_ch.valid && !pair_taken) begin
      // hold the offered request
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      pair_ch.valid <= 1'b0;
    end else if (pending_pairs.size() > 0) begin
      pair_ch.data  <= pending_pairs.pop_front();
      pair_ch.valid <= 1'b1;
      send_gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
    end else begin
      pair_ch.valid <= 1'b0;
    end
  end

  // accepted requests are predicted at the edge they are taken
  always @(posedge clk) begin
    pair_taken <= !rst && pair_ch.valid && pair_ch.ready;
    if (!rst && pair_ch.valid && pair_ch.ready)
      expected_results.insert(expected_results.size(),
                              resolve_pair(pair_ch.data, rest_q));
  end

  // ---------------------------------------------------------------- receiver
  int recv_gap = 0;
  always @(negedge clk) begin
    int g;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_hold) begin
      res_ch.ready <= 1'b0;
    end else if (res_taken) begin
      g = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
      if (g == 0) begin
        res_ch.ready <= 1'b1;
      end else begin
        recv_gap <= g - 1;
        res_ch.ready <= 1'b0;
      end
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // long hold-off so the pipeline fills and back-pressures its input
  always @(negedge clk) begin
    if (hold_len > 0) begin
      stall_hold <= 1'b1;
      hold_len <= hold_len - 1;
    end else begin
      stall_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    result_t exp_r, got;
    res_taken <= !rst && res_ch.valid && res_ch.ready;
    if (!rst) begin
      if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", exp_r, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [POS_W-1:0] rnd_pos();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF - 24'($urandom_range(0, 3));
      1: return 24'sh800000 + 24'($urandom_range(0, 3));
      2: return 24'($urandom);
      default: return $signed(24'($urandom_range(0, 40000))) - 24'sd20000;
    endcase
  endfunction

  function automatic logic [MASS_W-1:0] rnd_mass();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rnd_vel();
    if ($urandom_range(0, 4) == 0) return 24'($urandom);
    return $signed(24'($urandom_range(0, 8000))) - 24'sd4000;
  endfunction

  // mostly overlapping pairs, sometimes far apart or fully random
  function automatic pair_t rnd_pair();
    pair_t p;
    int sep;
    p.pos_a_x = rnd_pos();
    p.pos_a_y = rnd_pos();
    p.radius_a = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 8000));
    p.radius_b = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 8000));
    p.mass_a = rnd_mass();
    p.mass_b = rnd_mass();
    p.vel_a_x = rnd_vel();
    p.vel_a_y = rnd_vel();
    p.vel_b_x = rnd_vel();
    p.vel_b_y = rnd_vel();
    sep = p.radius_a + p.radius_b + 1;
    if ($urandom_range(0, 9) == 0) begin
      p.pos_b_x = 24'($urandom);
      p.pos_b_y = 24'($urandom);
    end else begin
      p.pos_b_x = p.pos_a_x + 24'($urandom_range(0, 2 * sep)) - 24'(sep);
      p.pos_b_y = p.pos_a_y + 24'($urandom_range(0, 2 * sep)) - 24'(sep);
    end
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || expected_results.size() != 0 || pair_ch.valid)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_rest(logic [REST_W-1:0] v);
    @(negedge clk);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    rest_q = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    repeat (n) queue_pair(rnd_pair());
  endtask

  initial begin
    pair_t p;
    pair_ch.valid = 1'b0;
    pair_ch.data  = '0;
    res_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    rest_q = REST_RESET;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: base pair head-on, then variations
    p = '0;
    p.radius_a = 17'd2560; p.radius_b = 17'd2560;
    p.mass_a = 16'd10; p.mass_b = 16'd10;
    p.pos_b_x = 24'sd2000; p.vel_a_x = 24'sd512; p.vel_b_x = -24'sd512;
    queue_pair(p);                                   // approaching
    p.vel_a_x = -24'sd512; p.vel_b_x = 24'sd512;
    queue_pair(p);                                   // receding
    p.vel_a_x = '0; p.vel_b_x = '0;
    queue_pair(p);                                   // zero approach speed
    p.pos_b_x = '0;
    queue_pair(p);                                   // coincident centres
    p.pos_b_x = 24'sd1; p.radius_a = 17'h1FFFF;
    queue_pair(p);                                   // tiny offset
    p.pos_b_x = 24'sd9000; p.radius_a = 17'd100;
    queue_pair(p);                                   // apart
    p.pos_b_x = 24'sd300; p.pos_b_y = -24'sd200; p.radius_a = 17'd2560;
    p.mass_a = '0; p.mass_b = '0; p.vel_a_y = 24'sd900;
    queue_pair(p);                                   // both masses zero
    p.mass_b = 16'hFFFF;
    queue_pair(p);                                   // one mass zero
    p.mass_a = 16'hFFFF; p.mass_b = 16'd1;
    queue_pair(p);
    p.pos_a_x = 24'sh7FFFFF; p.pos_b_x = 24'sh7FFFF0; p.pos_a_y = '0; p.pos_b_y = '0;
    p.radius_a = 17'h1FFFF; p.radius_b = 17'h1FFFF;
    p.vel_a_x = 24'sh7FFFFF; p.vel_b_x = 24'sh800000;
    queue_pair(p);                                   // saturation high
    p.pos_a_x = 24'sh800000; p.pos_b_x = 24'sh800010;
    p.vel_a_x = 24'sh800000; p.vel_b_x = 24'sh7FFFFF;
    queue_pair(p);                                   // saturation low
    p.pos_a_x = 24'sh800000; p.pos_b_x = 24'sh7FFFFF;
    queue_pair(p);                                   // extreme far apart
    random_phase(8);
    wait_drained();

    random_phase(186);
    // pressure: hold the receiver off while the sender keeps offering
    wait (expected_results.size() > 10);
    hold_len = 150;
    wait_drained();

    write_rest(16'd0);
    random_phase(186);
    wait_drained();
    write_rest(16'hFFFF);
    random_phase(186);
    wait_drained();
    write_rest(16'($urandom));
    random_phase(186);
    wait_drained();

    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
